[hw/rtl/rle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg: shared types and constants of the run-length scanline decoder
// Request payload types, divider status bundle and register indexes.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Request payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_start;
    } t_in_req;

    typedef struct packed {
        logic [7:0] pixel;
        logic [6:0] run_length;
        logic       line_end;
        logic       overrun;
    } t_out_req;

    // Divider status toward the decoder
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Configuration register indexes
    localparam logic [1:0] REG_PIXEL_MIN  = 2'd0;
    localparam logic [1:0] REG_PIXEL_MAX  = 2'd1;
    localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

    localparam int unsigned CFG_W    = 16;
    localparam int unsigned DVD_W    = 16;
    localparam int unsigned CNT_W    = 17;

    localparam logic [7:0]       FULL_SCALE = 8'd255;
    localparam logic [CNT_W-1:0] PIXCNT_MAX = {CNT_W{1'b1}};

endpackage

[hw/rtl/rle_scanline_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_scanline_decoder: 8-bit run-length scanline decoder with rescaling
// Expands control/literal/repeat bytes into (pixel, run length) requests,
// rescales each pixel from pixel_min..pixel_max to 0..255, flags overrun.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  input     i_in_valid / o_in_ready / i_in_data       in
//  output    o_out_valid / i_out_ready / o_out_data    out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data         in
//
//  Flow: a control byte that makes no request leaves the input ready; a
//  byte that makes a request frees the input once the request moves on to
//  the output register. A pixel above pixel_min with a proper range first
//  goes through the bit-serial divider: load, divide, then quotient hand-off.
//  Reset: synchronous, active low; clears decode state and loads the
//  register defaults (min 0, max 255, width 65535).
//  Stalls: a finished request waits in the output register; the next byte
//  is still accepted and decoded while it waits, and holds in the pending
//  stage until the output register frees up.
// ----------------------------------------------------------------------------
module rle_scanline_decoder
    import rle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // decode modes
    localparam logic [1:0] MODE_CONTROL = 2'd0;
    localparam logic [1:0] MODE_LITERAL = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;
    localparam logic [1:0] MODE_DONE    = 2'd3;

    // configuration
    logic [7:0]       r_pix_min;
    logic [7:0]       r_pix_max;
    logic [15:0]      r_line_width;

    // decode state
    logic [1:0]       r_mode, n_mode;
    logic [6:0]       r_lit, n_lit;
    logic [6:0]       r_rep, n_rep;
    logic [CNT_W-1:0] r_pix_cnt, n_pix_cnt;

    // pending stage (waits on the divider and on the output register)
    logic             r_pend_valid, n_pend_valid;
    logic             r_pend_div, n_pend_div;
    t_out_req         r_pend, n_pend;

    // output register
    logic             r_out_valid, n_out_valid;
    t_out_req         r_out, n_out;

    // divider hookup
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [7:0]       div_divisor;
    t_div_stat        s_div;
    logic [7:0]       div_quot;

    logic             in_fire;
    logic [1:0]       eff_mode;
    logic [6:0]       eff_lit;
    logic [6:0]       eff_rep;
    logic [CNT_W-1:0] eff_cnt;
    logic [6:0]       ctl_cnt;
    logic [6:0]       pix_inc;
    logic [CNT_W:0]   cnt_sum;
    logic [CNT_W-1:0] cnt_new;
    logic [7:0]       diff_v;
    logic             range_ok;
    logic             above_min;
    logic             pend_move;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_pend_valid;

    // line_start clears the decoder before the byte is interpreted
    assign eff_mode = i_in_data.line_start ? MODE_CONTROL : r_mode;
    assign eff_lit  = i_in_data.line_start ? 7'd0 : r_lit;
    assign eff_rep  = i_in_data.line_start ? 7'd0 : r_rep;
    assign eff_cnt  = i_in_data.line_start ? {CNT_W{1'b0}} : r_pix_cnt;
    assign ctl_cnt  = i_in_data.data_byte[6:0];

    // pixels added by this byte: one for a literal, the run for a repeat
    assign pix_inc  = (eff_mode == MODE_REPEAT) ? eff_rep : 7'd1;
    assign cnt_sum  = {1'b0, eff_cnt} + {{(CNT_W - 6){1'b0}}, pix_inc};
    assign cnt_new  = cnt_sum[CNT_W] ? PIXCNT_MAX : cnt_sum[CNT_W-1:0];

    // rescale setup: numerator (v - min) * 255, divisor max - min
    assign range_ok     = r_pix_min < r_pix_max;
    assign above_min    = i_in_data.data_byte > r_pix_min;
    assign diff_v       = i_in_data.data_byte - r_pix_min;
    assign div_dividend = {diff_v, 8'd0} - {8'd0, diff_v};
    assign div_divisor  = r_pix_max - r_pix_min;

    assign pend_move = r_pend_valid && !r_pend_div && (!r_out_valid || i_out_ready);

    always_comb begin
        n_mode       = r_mode;
        n_lit        = r_lit;
        n_rep        = r_rep;
        n_pix_cnt    = r_pix_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_div   = r_pend_div;
        n_pend       = r_pend;
        div_start    = 1'b0;

        // divider finished: drop the quotient into the pending request
        if (r_pend_div && s_div.done) begin
            n_pend.pixel = div_quot;
            n_pend_div   = 1'b0;
        end
        if (pend_move) begin
            n_pend_valid = 1'b0;
        end

        if (in_fire) begin
            n_mode    = eff_mode;
            n_lit     = eff_lit;
            n_rep     = eff_rep;
            n_pix_cnt = eff_cnt;
            case (eff_mode)
                MODE_CONTROL: begin
                    if (ctl_cnt == 7'd0) begin
                        n_mode              = MODE_DONE;
                        n_pend_valid        = 1'b1;
                        n_pend_div          = 1'b0;
                        n_pend.pixel        = 8'd0;
                        n_pend.run_length   = 7'd0;
                        n_pend.line_end     = 1'b1;
                        n_pend.overrun      = eff_cnt > {1'b0, r_line_width};
                    end else if (i_in_data.data_byte[7]) begin
                        n_lit  = ctl_cnt;
                        n_mode = MODE_LITERAL;
                    end else begin
                        n_rep  = ctl_cnt;
                        n_mode = MODE_REPEAT;
                    end
                end
                MODE_LITERAL, MODE_REPEAT: begin
                    n_pix_cnt         = cnt_new;
                    n_pend_valid      = 1'b1;
                    n_pend.line_end   = 1'b0;
                    n_pend.overrun    = cnt_new > {1'b0, r_line_width};
                    if (eff_mode == MODE_LITERAL) begin
                        n_lit             = eff_lit - 7'd1;
                        n_pend.run_length = 7'd1;
                        if (eff_lit == 7'd1) begin
                            n_mode = MODE_CONTROL;
                        end
                    end else begin
                        n_rep             = 7'd0;
                        n_pend.run_length = eff_rep;
                        n_mode            = MODE_CONTROL;
                    end
                    // hold for the divider only with a proper range above min
                    if (range_ok && above_min) begin
                        div_start    = 1'b1;
                        n_pend_div   = 1'b1;
                        n_pend.pixel = 8'd0;
                    end else begin
                        n_pend_div   = 1'b0;
                        n_pend.pixel = above_min ? FULL_SCALE : 8'd0;
                    end
                end
                default: begin
                    // line already ended: ignore bytes until line_start
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (pend_move) begin
            n_out_valid = 1'b1;
            n_out       = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_min    <= 8'd0;
            r_pix_max    <= 8'd255;
            r_line_width <= 16'hffff;
            r_mode       <= MODE_CONTROL;
            r_lit        <= 7'd0;
            r_rep        <= 7'd0;
            r_pix_cnt    <= {CNT_W{1'b0}};
            r_pend_valid <= 1'b0;
            r_pend_div   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PIXEL_MIN:  r_pix_min    <= i_cfg_data[7:0];
                    REG_PIXEL_MAX:  r_pix_max    <= i_cfg_data[7:0];
                    REG_LINE_WIDTH: r_line_width <= i_cfg_data[15:0];
                    default: begin
                        // no register at this index
                    end
                endcase
            end
            r_mode       <= n_mode;
            r_lit        <= n_lit;
            r_rep        <= n_rep;
            r_pix_cnt    <= n_pix_cnt;
            r_pend_valid <= n_pend_valid;
            r_pend_div   <= n_pend_div;
            r_out_valid  <= n_out_valid;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    rle_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (s_div),
        .o_quot     (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a request waiting on a quotient always has the divider working on it
    a_pend_has_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && r_pend_div |-> s_div.busy || s_div.done)
        else $error("pending request waits on an idle divider");

    // the divider is never restarted while it works
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !s_div.busy && !r_pend_valid)
        else $error("divider started while busy");

    // a line end request carries no pixel and no run
    a_line_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_end |->
            o_out_data.pixel == 8'd0 && o_out_data.run_length == 7'd0)
        else $error("line end request with pixel data");

    // a pixel request always has a nonzero run
    a_pixel_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.line_end |-> o_out_data.run_length != 7'd0)
        else $error("pixel request with empty run");

endmodule

[hw/rtl/rle_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_div: radix-2 restoring divider, 16-bit dividend by 8-bit divisor
// Shifts one quotient bit per cycle; result saturates to 8 bits.
// ----------------------------------------------------------------------------
module rle_div
    import rle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [7:0]       i_divisor,
    output t_div_stat        o_stat,
    output logic [7:0]       o_quot
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [3:0]       r_cnt, n_cnt;
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [7:0]       r_rem, n_rem;
    logic [7:0]       r_dvs, n_dvs;
    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             ge;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd0;
            n_dvd  = i_dividend;
            n_rem  = 8'd0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem = ge ? diff[7:0] : trial[7:0];
            n_dvd = {r_dvd[DVD_W-2:0], ge};
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    // quotient above 255 saturates
    assign o_quot      = (|r_dvd[DVD_W-1:8]) ? FULL_SCALE : r_dvd[7:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[dv/tb_rle_scanline_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_scanline_decoder: self-checking testbench of the run-length decoder
// Feeds control, literal and repeat bytes under several range and width
// settings, predicts every (pixel, run length) request in the bench, and
// checks each output request field by field under random stalls.
// ----------------------------------------------------------------------------
module tb_rle_scanline_decoder;
    import rle_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned SETTLE_WAIT  = 40;     // covers a full divider pass
    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned MAX_PRINTS   = 60;

    // Index that maps to no register; writes to it must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int unsigned LIT_FLAG_BIT = 7;
    localparam logic [6:0]  COUNT_END    = 7'd0;
    localparam logic [6:0]  COUNT_MAX    = 7'h7f;

    typedef enum logic [1:0] {
        DEC_CONTROL,
        DEC_LITERAL,
        DEC_REPEAT,
        DEC_DONE
    } t_dec_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_req          i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_req         o_out_data;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    rle_scanline_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Decoder state as the bench sees it
    t_dec_mode        dec_mode;
    logic [6:0]       lit_left;
    logic [6:0]       rep_len;
    logic [CNT_W-1:0] pix_count;

    // Shadow copies of the configuration registers
    logic [7:0]       cfg_min;
    logic [7:0]       cfg_max;
    logic [15:0]      cfg_width;

    t_out_req         expected_runs_q[$];

    int unsigned      error_count;
    int unsigned      items_sent;
    int unsigned      cycle_count;

    // Idling knobs: sender gaps, receiver bursts and one long hold-off
    bit               tx_gaps;
    bit               rx_stalls;
    int unsigned      rx_hold_cycles;
    int unsigned      rx_burst_left;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Stop a hung run; the limit is many times the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** rle_scanline_decoder: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Rescale a raw sample from cfg_min..cfg_max onto 0..255
    function automatic logic [7:0] scale_sample(input logic [7:0] v);
        int unsigned quot;
        // Flat or inverted range: threshold at the minimum
        if (cfg_min >= cfg_max)
            return (v > cfg_min) ? FULL_SCALE : 8'd0;
        if (v <= cfg_min)
            return 8'd0;
        quot = ((32'(v) - 32'(cfg_min)) * 32'(FULL_SCALE)) /
               (32'(cfg_max) - 32'(cfg_min));
        return (quot > 32'(FULL_SCALE)) ? FULL_SCALE : quot[7:0];
    endfunction

    // Add pixels to the line total; clamp at the counter maximum
    function automatic void add_pixels(input logic [6:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, pix_count} + (CNT_W + 1)'(n);
        pix_count = (sum > {1'b0, PIXCNT_MAX}) ? PIXCNT_MAX : sum[CNT_W-1:0];
    endfunction

    // Advance the decoder by one byte; return 1 with the request it makes
    function automatic bit expand_byte(input t_in_req req, output t_out_req res);
        logic [6:0] cnt;
        bit         made;
        cnt  = req.data_byte[6:0];
        made = 1'b0;
        res  = '0;
        // A line start wipes the line state before the byte is decoded
        if (req.line_start) begin
            dec_mode  = DEC_CONTROL;
            lit_left  = '0;
            rep_len   = '0;
            pix_count = '0;
        end
        case (dec_mode)
            DEC_CONTROL: begin
                if (cnt == COUNT_END) begin
                    // Zero count ends the line, literal flag or not
                    dec_mode     = DEC_DONE;
                    res.line_end = 1'b1;
                    made         = 1'b1;
                end else if (req.data_byte[LIT_FLAG_BIT]) begin
                    lit_left = cnt;
                    dec_mode = DEC_LITERAL;
                end else begin
                    rep_len  = cnt;
                    dec_mode = DEC_REPEAT;
                end
            end
            DEC_LITERAL: begin
                add_pixels(7'd1);
                lit_left = lit_left - 7'd1;
                if (lit_left == '0)
                    dec_mode = DEC_CONTROL;
                res.pixel      = scale_sample(req.data_byte);
                res.run_length = 7'd1;
                made           = 1'b1;
            end
            DEC_REPEAT: begin
                add_pixels(rep_len);
                res.pixel      = scale_sample(req.data_byte);
                res.run_length = rep_len;
                rep_len        = '0;
                dec_mode       = DEC_CONTROL;
                made           = 1'b1;
            end
            default: begin
                // Line already ended: drop bytes until the next line start
            end
        endcase
        if (made)
            res.overrun = (pix_count > CNT_W'(cfg_width));
        return made;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: receiver stalls and result check
    // ------------------------------------------------------------------------
    // Drive ready at the falling edge: long hold-off first, then bursts
    initial begin
        i_out_ready   = 1'b0;
        rx_burst_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                i_out_ready = 1'b0;
                rx_hold_cycles--;
            end else if (rx_burst_left != 0) begin
                i_out_ready = 1'b0;
                rx_burst_left--;
            end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
                i_out_ready   = 1'b0;
                rx_burst_left = $urandom_range(1, 6) - 1;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare every accepted output request with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_req want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_runs_q.size() == 0) begin
                report_mismatch($sformatf("unexpected request pixel=%0d run=%0d end=%0b",
                    o_out_data.pixel, o_out_data.run_length, o_out_data.line_end));
            end else begin
                want = expected_runs_q.pop_front();
                if (o_out_data.pixel !== want.pixel)
                    report_mismatch($sformatf("pixel expected %0d got %0d",
                        want.pixel, o_out_data.pixel));
                if (o_out_data.run_length !== want.run_length)
                    report_mismatch($sformatf("run_length expected %0d got %0d",
                        want.run_length, o_out_data.run_length));
                if (o_out_data.line_end !== want.line_end)
                    report_mismatch($sformatf("line_end expected %0b got %0b",
                        want.line_end, o_out_data.line_end));
                if (o_out_data.overrun !== want.overrun)
                    report_mismatch($sformatf("overrun expected %0b got %0b",
                        want.overrun, o_out_data.overrun));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one byte at the falling edge and hold it until accepted.
    // Valid stays high afterward so back-to-back requests need no gap;
    // anything that stops sending must drop valid first.
    task automatic send_byte(input logic [7:0] b, input logic ls);
        t_in_req  req;
        t_out_req res;
        req.data_byte  = b;
        req.line_start = ls;
        i_in_valid = 1'b1;
        i_in_data  = req;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        if (expand_byte(req, res))
            expected_runs_q.push_back(res);
        items_sent++;
        @(negedge i_clk);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            i_in_data  = t_in_req'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Stop sending, wait for every predicted request, then let the
    // block finish any control byte still in flight
    task automatic drain();
        i_in_valid = 1'b0;
        while (expected_runs_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    // Write one register; only called with the block idle
    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_in_valid = 1'b0;
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            REG_PIXEL_MIN:  cfg_min   = data[7:0];
            REG_PIXEL_MAX:  cfg_max   = data[7:0];
            REG_LINE_WIDTH: cfg_width = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = CFG_W'($urandom);
    endtask

    // Load all three registers; junk in the upper bits of the 8-bit ones
    task automatic load_config(input logic [7:0] lo, input logic [7:0] hi,
                               input logic [15:0] width);
        drain();
        cfg_write(REG_PIXEL_MIN, {8'($urandom), lo});
        cfg_write(REG_PIXEL_MAX, {8'($urandom), hi});
        cfg_write(REG_LINE_WIDTH, width);
    endtask

    function automatic logic [7:0] ctrl_byte(input bit literal, input logic [6:0] n);
        return {literal, n};
    endfunction

    // One well-formed line with random content, now and then broken by
    // a stray byte, a missing end or bytes trailing the end
    task automatic send_random_line();
        int unsigned runs;
        int unsigned n;
        logic        first;
        runs  = $urandom_range(1, 8);
        first = 1'b1;
        for (int r = 0; r < runs; r++) begin
            if ($urandom_range(0, 24) == 0)
                send_byte(8'($urandom), 1'($urandom));
            if ($urandom_range(0, 1) == 1) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127)
                                                  : $urandom_range(1, 6);
                send_byte(ctrl_byte(1'b1, 7'(n)), first);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom), 1'b0);
            end else begin
                send_byte(ctrl_byte(1'b0, 7'($urandom_range(1, 127))), first);
                send_byte(8'($urandom), 1'b0);
            end
            first = 1'b0;
        end
        if ($urandom_range(0, 5) != 0)
            send_byte(ctrl_byte(1'($urandom), COUNT_END), 1'b0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Default range: literal, repeat, line end, bytes after the end,
    // line start in the middle of a literal run
    task automatic test_decode_basics();
        send_byte(ctrl_byte(1'b1, 7'd3), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(ctrl_byte(1'b0, COUNT_MAX), 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(ctrl_byte(1'b0, 7'd1), 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(ctrl_byte(1'b1, 7'd1), 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(ctrl_byte(1'b0, COUNT_END), 1'b0);
        // Line is over: these must change nothing
        send_byte(ctrl_byte(1'b1, 7'd3), 1'b0);
        send_byte(8'h12, 1'b0);
        // Zero count with the literal flag still ends the line
        send_byte(ctrl_byte(1'b1, COUNT_END), 1'b1);
        // Restart in the middle of a literal run, and on a repeat pixel
        send_byte(ctrl_byte(1'b1, 7'd5), 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(ctrl_byte(1'b0, 7'd2), 1'b1);
        send_byte(8'h40, 1'b0);
        send_byte(ctrl_byte(1'b0, 7'd4), 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(ctrl_byte(1'b1, 7'd127), 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(ctrl_byte(1'b0, COUNT_END), 1'b1);
    endtask

    // One short line that hits zero, the range ends and full scale
    task automatic send_scaling_line();
        send_byte(ctrl_byte(1'b1, 7'd6), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(cfg_min, 1'b0);
        send_byte(cfg_min + 8'd1, 1'b0);
        send_byte(cfg_max, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(ctrl_byte(1'b0, 7'($urandom_range(1, 127))), 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(ctrl_byte(1'b0, COUNT_END), 1'b0);
    endtask

    // Walk the registers through their extremes and degenerate ranges
    task automatic test_range_and_width();
        load_config(8'd16, 8'd235, 16'd65535);
        send_scaling_line();
        load_config(8'd0, 8'd1, 16'd1);             // steepest scale, tight width
        send_scaling_line();
        load_config(8'd254, 8'd255, 16'd0);         // zero width: all overrun
        send_scaling_line();
        load_config(8'd100, 8'd100, 16'd7);         // flat range
        send_scaling_line();
        load_config(8'd200, 8'd50, 16'd130);        // inverted range
        send_scaling_line();
        load_config(8'd255, 8'd0, 16'd65535);
        send_scaling_line();
        // A write to the spare index must not disturb any register
        drain();
        cfg_write(REG_UNUSED, 16'hffff);
        load_config(8'd0, 8'd255, 16'd65535);
        send_scaling_line();
    endtask

    // Hold the receiver off for a long stretch while bytes keep coming,
    // so the output register and pending stage fill and input stalls
    task automatic test_output_stall();
        load_config(8'd10, 8'd240, 16'd50);
        tx_gaps        = 1'b0;
        rx_hold_cycles = 300;
        repeat (3) send_random_line();
        tx_gaps = 1'b1;
        drain();
    endtask

    // Random lines under random settings; last part runs with no idling
    task automatic test_random_lines();
        int unsigned start_count;
        int unsigned next_cfg;
        logic [7:0]  lo;
        logic [7:0]  hi;
        start_count = items_sent;
        next_cfg    = items_sent;
        while (items_sent < start_count + RANDOM_ITEMS) begin
            if (items_sent >= next_cfg) begin
                lo = 8'($urandom_range(0, 200));
                hi = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(lo + 1, 255));
                load_config(lo, hi, ($urandom_range(0, 2) == 0)
                    ? 16'hffff : 16'($urandom_range(1, 300)));
                next_cfg = items_sent + 250;
            end
            if (items_sent >= start_count + (RANDOM_ITEMS * 4) / 5) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            send_random_line();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_PIXEL_MIN;
        i_cfg_data     = '0;
        error_count    = 0;
        items_sent     = 0;
        cycle_count    = 0;
        tx_gaps        = 1'b1;
        rx_stalls      = 1'b1;
        rx_hold_cycles = 0;
        // Reset values of the decoder and its registers
        dec_mode       = DEC_CONTROL;
        lit_left       = '0;
        rep_len        = '0;
        pix_count      = '0;
        cfg_min        = 8'd0;
        cfg_max        = 8'd255;
        cfg_width      = 16'd65535;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_decode_basics();
        test_range_and_width();
        test_output_stall();
        test_random_lines();
        drain();

        if (error_count == 0)
            $display("** rle_scanline_decoder: PASSED **");
        else
            $display("** rle_scanline_decoder: FAILED **");
        $finish;
    end

endmodule
